// ===== hdl/edbp_pkg.sv =====
// ----------------------------------------------------------------------------
// edbp_pkg - shared types and constants of the Elias delta bit packer
// Request and result payloads, the code entry passed from front to back,
// and register map constants.
// ----------------------------------------------------------------------------
`default_nettype none

package edbp_pkg;

    localparam int WORD_BITS  = 32;
    // longest code: 11 bits of gamma prefix plus 31 bits of mantissa
    localparam int CODE_BITS  = 42;
    // pending bits (at most 31) plus one full code
    localparam int BUF_BITS   = WORD_BITS + CODE_BITS - 1;
    localparam int LEN_W      = $clog2(CODE_BITS + 1);
    localparam int CNT_W      = $clog2(BUF_BITS + 1);
    localparam int WCOUNT_W   = 27;

    localparam int QUEUE_DEPTH_DEF = 4;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_BYTES_PER_NUMBER = 1'b0;  // register index, paddr[2]
    localparam logic [2:0] BPN_RESET = 3'd4;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } edbp_src_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  valid_bytes;
        logic        end_of_stream;
        logic [31:0] total_bits;
    } edbp_dst_t;

    // one code, left aligned in CODE_BITS, with its length
    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic [LEN_W-1:0]     len;
        logic                 last;
    } edbp_code_t;

endpackage

`default_nettype wire

// ===== hdl/edbp_front.sv =====
// ----------------------------------------------------------------------------
// edbp_front - request intake and code builder
// Masks and increments the value, then builds the left-aligned delta code
// and its length for the code queue.
// ----------------------------------------------------------------------------
`default_nettype none

module edbp_front
    import edbp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [2:0] bytes_per_number,
    input  wire logic       src_valid,
    output logic            src_stall,
    input  wire edbp_src_t  src_data,
    output logic            push,
    output edbp_code_t      push_data,
    input  wire logic       queue_full
);

    logic        s_valid_reg;
    logic [31:0] num_reg;
    logic        last_reg;
    logic [31:0] num_next;
    logic [31:0] masked;

    logic [5:0]  n_len;     // bit length of num, 1..32
    logic [2:0]  l_len;     // bit length of n_len, 1..6
    logic [3:0]  gamma_len;
    logic [3:0]  gamma_sh;
    logic [10:0] gamma;
    logic [5:0]  tail_sh;
    logic [31:0] tail;

    assign src_stall = s_valid_reg && queue_full;
    assign push      = s_valid_reg && !queue_full;

    // input mask, register values out of range clamp to 1 or 4 bytes
    always_comb
    begin
        case (bytes_per_number)
            3'd0, 3'd1: masked = {24'd0, src_data.value[7:0]};
            3'd2:       masked = {16'd0, src_data.value[15:0]};
            3'd3:       masked = {8'd0, src_data.value[23:0]};
            default:    masked = src_data.value;
        endcase
        // saturating increment
        num_next = (&masked) ? masked : masked + 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (!src_stall)
        begin
            s_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!src_stall && src_valid)
        begin
            num_reg  <= num_next;
            last_reg <= src_data.last;
        end
    end

    // code = (L-1) zeros, N in L bits, low N-1 bits of num
    always_comb
    begin
        n_len = 6'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (num_reg[i])
            begin
                n_len = 6'(i + 1);
            end
        end
        l_len = 3'd0;
        for (int j = 0; j < 6; j++)
        begin
            if (n_len[j])
            begin
                l_len = 3'(j + 1);
            end
        end
        gamma_len = {l_len, 1'b0} - 4'd1;
        gamma_sh  = 4'd12 - {l_len, 1'b0};
        gamma     = {5'd0, n_len} << gamma_sh;
        tail_sh   = 6'd33 - n_len;
        tail      = num_reg << tail_sh;      // drops the leading one

        push_data.code = {gamma, 31'd0} | ({tail, 10'd0} >> gamma_len);
        push_data.len  = LEN_W'(gamma_len) + n_len - LEN_W'(1);
        push_data.last = last_reg;
    end

endmodule

`default_nettype wire

// ===== hdl/edbp_queue.sv =====
// ----------------------------------------------------------------------------
// edbp_queue - code queue between front and back
// Small register FIFO; head entry is shown while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module edbp_queue
    import edbp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire edbp_code_t push_data,
    output logic            full,
    output logic            head_valid,
    output edbp_code_t      head_data,
    input  wire logic       pop
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    edbp_code_t         entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;

    assign full       = (count_reg == COUNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + COUNT_W'(1);
                2'b01:   count_reg <= count_reg - COUNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/edbp_back.sv =====
// ----------------------------------------------------------------------------
// edbp_back - bit packer and word output
// Merges codes into a bit buffer, emits one 32-bit word per cycle into the
// output register unless dst stalls, and flushes a stream's partial word.
// ----------------------------------------------------------------------------
`default_nettype none

module edbp_back
    import edbp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  wire edbp_code_t head_data,
    output logic            pop,
    output logic            dst_valid,
    input  wire logic       dst_stall,
    output edbp_dst_t       dst_data
);

    logic [BUF_BITS-1:0] wbuf_reg, wbuf_next;
    logic [CNT_W-1:0]    wcnt_reg, wcnt_next;
    logic [WCOUNT_W-1:0] words_reg, words_next;
    logic                wlast_reg, wlast_next;
    logic                dst_valid_reg, dst_valid_next;
    edbp_dst_t           dst_reg, dst_next;

    logic                can_out;
    logic                have_word;
    logic                do_full;
    logic                do_flush;
    logic                eos_full;
    logic [BUF_BITS-1:0] base_buf;
    logic [CNT_W-1:0]    base_cnt;
    logic [BUF_BITS-1:0] ins_bits;
    logic [2:0]          flush_bytes;

    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_reg;

    always_comb
    begin
        can_out   = !dst_valid_reg || !dst_stall;
        have_word = (wcnt_reg >= CNT_W'(WORD_BITS));
        do_full   = have_word && can_out;
        do_flush  = !have_word && wlast_reg && can_out;
        eos_full  = do_full && wlast_reg && (wcnt_reg == CNT_W'(WORD_BITS));

        // consume a finished word first, then merge the next code behind it
        base_buf = do_full ? {wbuf_reg[BUF_BITS-WORD_BITS-1:0], {WORD_BITS{1'b0}}} : wbuf_reg;
        base_cnt = do_full ? wcnt_reg - CNT_W'(WORD_BITS) : wcnt_reg;
        pop      = head_valid && !wlast_reg && (base_cnt < CNT_W'(WORD_BITS));
        ins_bits = {head_data.code, {(WORD_BITS-1){1'b0}}} >> base_cnt[4:0];

        if (wcnt_reg > CNT_W'(24))
            flush_bytes = 3'd4;
        else if (wcnt_reg > CNT_W'(16))
            flush_bytes = 3'd3;
        else if (wcnt_reg > CNT_W'(8))
            flush_bytes = 3'd2;
        else
            flush_bytes = 3'd1;

        wbuf_next  = pop ? (base_buf | ins_bits) : base_buf;
        wcnt_next  = pop ? base_cnt + CNT_W'(head_data.len) : base_cnt;
        words_next = words_reg;
        wlast_next = pop ? head_data.last : wlast_reg;

        dst_valid_next = dst_valid_reg && dst_stall;
        dst_next       = dst_reg;

        if (do_full)
        begin
            dst_valid_next         = 1'b1;
            dst_next.word          = wbuf_reg[BUF_BITS-1 -: WORD_BITS];
            dst_next.valid_bytes   = 3'd4;
            dst_next.end_of_stream = eos_full;
            dst_next.total_bits    = eos_full ? {words_reg + WCOUNT_W'(1), 5'd0} : 32'd0;
            words_next             = words_reg + WCOUNT_W'(1);
            if (eos_full)
            begin
                words_next = '0;
                wlast_next = 1'b0;
            end
        end
        else if (do_flush)
        begin
            dst_valid_next         = 1'b1;
            dst_next.word          = wbuf_reg[BUF_BITS-1 -: WORD_BITS];
            dst_next.valid_bytes   = flush_bytes;
            dst_next.end_of_stream = 1'b1;
            dst_next.total_bits    = {words_reg, wcnt_reg[4:0]};
            wbuf_next              = '0;
            wcnt_next              = '0;
            words_next             = '0;
            wlast_next             = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wbuf_reg      <= '0;
            wcnt_reg      <= '0;
            words_reg     <= '0;
            wlast_reg     <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            wbuf_reg      <= wbuf_next;
            wcnt_reg      <= wcnt_next;
            words_reg     <= words_next;
            wlast_reg     <= wlast_next;
            dst_valid_reg <= dst_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg <= dst_next;
    end

    // buffer never holds more than pending bits plus one code
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        wcnt_reg <= CNT_W'(BUF_BITS))
        else $error("bit buffer count out of range");

    // a stream end below a word boundary always leaves bits to flush
    a_flush_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (wlast_reg && !have_word) |-> (wcnt_reg != '0))
        else $error("end of stream with empty partial word");

    // closing a stream always produces an end-of-stream word
    a_eos_out: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(wlast_reg) |-> (dst_valid_reg && dst_reg.end_of_stream))
        else $error("stream closed without end-of-stream word");

    a_mid_word: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid_reg && !dst_reg.end_of_stream)
            |-> (dst_reg.valid_bytes == 3'd4 && dst_reg.total_bits == 32'd0))
        else $error("mid-stream word with partial count");

endmodule

`default_nettype wire

// ===== hdl/elias_delta_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// elias_delta_bit_packer_unit - Elias delta encoder with 32-bit word packing
//
// Requests arrive on src (valid/stall): a value and a last flag. The value
// is masked to bytes_per_number bytes, incremented (saturating at all ones)
// and encoded as an Elias delta code, MSB first. Code bits are packed into
// 32-bit words, first bit in bit 31, and sent on dst (valid/stall). The
// request marked last closes the stream: its final word carries
// end_of_stream and total_bits, partial words are zero padded and report
// their meaningful leading bytes in valid_bytes.
//
// A word completed by a request passes the front register, code queue,
// bit buffer and output register before it leaves on dst. A new request
// is taken every cycle while the code queue (4 entries by default) has
// room; the packer merges at most one code and writes at most one word per
// cycle to dst, so long codes (up to 42 bits) can hold back intake while
// short ones keep pace. When dst stalls, the output register holds, the
// packer stops once a full word is pending, the queue fills and src_stall
// rises. Reset clears the stream state, the queue and the output valid,
// and sets bytes_per_number to 4. Configure only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module elias_delta_bit_packer_unit
    import edbp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request channel
    input  wire logic                  src_valid,
    output logic                       src_stall,
    input  wire edbp_src_t             src_data,
    // result channel
    output logic                       dst_valid,
    input  wire logic                  dst_stall,
    output edbp_dst_t                  dst_data,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [2:0] bpn_reg;
    logic       cfg_write;

    logic       push;
    edbp_code_t push_data;
    logic       queue_full;
    logic       head_valid;
    edbp_code_t head_data;
    logic       pop;

    // ---- configuration register ----
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BYTES_PER_NUMBER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpn_reg <= BPN_RESET;
        end
        else if (cfg_write)
        begin
            bpn_reg <= pwdata[2:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_BYTES_PER_NUMBER)
            prdata = {{(CFG_DATA_W-3){1'b0}}, bpn_reg};
        else
            prdata = '0;
    end

    // ---- front: mask, increment, build code ----
    edbp_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .bytes_per_number (bpn_reg),
        .src_valid        (src_valid),
        .src_stall        (src_stall),
        .src_data         (src_data),
        .push             (push),
        .push_data        (push_data),
        .queue_full       (queue_full)
    );

    // ---- code queue decouples intake from word output ----
    edbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    // ---- back: pack bits, emit words, flush at end of stream ----
    edbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .dst_data   (dst_data)
    );

endmodule

`default_nettype wire
